>>> rtl/pcxrle_pkg.sv
// shared types and constants of the pcx run-length line encoder
`default_nettype none

package pcxrle_pkg;

	localparam int unsigned MAX_RESULTS = 4;

	localparam logic [5:0] RUN_LIMIT  = 6'd63;
	localparam logic [7:0] COUNT_MARK = 8'hC0;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_BYTES_PER_PLANE = 1'b0,
		REG_PLANE_COUNT     = 1'b1
	} reg_index_t;

	typedef logic [7:0] code_t;

	// one group of encoded bytes caused by a single item
	typedef struct packed {
		code_t [MAX_RESULTS-1:0] codes;
		logic  [2:0]             count;
		logic                    line_end;
	} result_group_t;

endpackage

`default_nettype wire

>>> rtl/pcx_rle_line_encoder_top.sv
// pcx run-length line encoder: run tracking, plane counting and output group buffer
// the first encoded byte of an item is valid in the cycle after the item is taken
// throughput: one item per cycle while items only extend a run; an item that closes runs
//   holds the next item back until its group of up to four bytes drains at one per cycle
//   while out_stall is low, set by the single output register group
// reset: arst_n clears run state, plane counters and the output group, and loads
//   bytes_per_plane = 640 and plane_count = 1
`default_nettype none

module pcx_rle_line_encoder_top
	import pcxrle_pkg::*;
#(
	parameter int unsigned MAX_PLANE_BYTES = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        wr_en,
	input  wire logic [0:0]  wr_index,
	input  wire logic [15:0] wr_data,
	// raw byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	// encoded byte channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       code_byte,
	output logic             last_of_item,
	output logic             line_end
);

	localparam logic [15:0] PLANE_MAX = 16'(MAX_PLANE_BYTES);

	// configuration registers
	logic [15:0] bytes_per_plane_q;
	logic [2:0]  plane_count_q;

	// run and position state
	logic [7:0]  run_value_q;
	logic [5:0]  run_length_q;
	logic [15:0] byte_in_plane_q;
	logic [1:0]  plane_index_q;

	// output group: codes of one item, drained one per cycle while out_stall is low
	result_group_t group_q;
	logic [1:0]    rd_q;

	result_group_t group_d;
	logic          in_accept;
	logic          out_accept;
	logic          group_free;

	logic [15:0] psize;
	logic [2:0]  planes;
	logic        close_first;
	logic        open_new;
	logic [7:0]  next_value;
	logic [5:0]  next_length;
	logic        plane_end;
	logic        line_done;
	logic [2:0]  n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_plane_q <= 16'd640;
			plane_count_q     <= 3'd1;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_BYTES_PER_PLANE: bytes_per_plane_q <= wr_data;
				REG_PLANE_COUNT:     plane_count_q     <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	// effective plane size and plane count after clamping
	always_comb begin
		psize = bytes_per_plane_q;
		if (psize == 16'd0)
			psize = 16'd1;
		if (psize > PLANE_MAX)
			psize = PLANE_MAX;
		planes = plane_count_q;
		if (planes == 3'd0)
			planes = 3'd1;
		if (planes > 3'd4)
			planes = 3'd4;
	end

	// encode one item: close the open run if it breaks, extend or open a run,
	// then close it again at a plane boundary
	always_comb begin
		group_d       = '0;
		n             = 3'd0;
		close_first   = (run_length_q != 6'd0) &&
			((data_byte != run_value_q) || (run_length_q >= RUN_LIMIT));
		if (close_first) begin
			if ((run_length_q > 6'd1) || (run_value_q[7:6] == 2'b11)) begin
				group_d.codes[n[1:0]] = COUNT_MARK | {2'b00, run_length_q};
				n = n + 3'd1;
			end
			group_d.codes[n[1:0]] = run_value_q;
			n = n + 3'd1;
		end

		open_new    = close_first || (run_length_q == 6'd0);
		next_value  = open_new ? data_byte : run_value_q;
		next_length = open_new ? 6'd1 : run_length_q + 6'd1;

		plane_end = ({1'b0, byte_in_plane_q} + 17'd1) >= {1'b0, psize};
		line_done = plane_end && (({1'b0, plane_index_q} + 3'd1) >= planes);

		if (plane_end) begin
			if ((next_length > 6'd1) || (next_value[7:6] == 2'b11)) begin
				group_d.codes[n[1:0]] = COUNT_MARK | {2'b00, next_length};
				n = n + 3'd1;
			end
			group_d.codes[n[1:0]] = next_value;
			n = n + 3'd1;
		end
		group_d.count    = n;
		group_d.line_end = line_done;
	end

	// handshakes: a new item goes in once the current group is drained or drains now
	assign out_valid    = {1'b0, rd_q} < group_q.count;
	assign out_accept   = out_valid && !out_stall;
	assign last_of_item = ({1'b0, rd_q} + 3'd1) == group_q.count;
	assign group_free   = !out_valid || (out_accept && last_of_item);
	assign in_stall     = !group_free;
	assign in_accept    = in_valid && group_free;

	assign code_byte = group_q.codes[rd_q];
	assign line_end  = group_q.line_end && last_of_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q     <= 8'd0;
			run_length_q    <= 6'd0;
			byte_in_plane_q <= 16'd0;
			plane_index_q   <= 2'd0;
		end else if (in_accept) begin
			run_value_q <= next_value;
			if (plane_end) begin
				run_length_q    <= 6'd0;
				byte_in_plane_q <= 16'd0;
				if (line_done)
					plane_index_q <= 2'd0;
				else
					plane_index_q <= plane_index_q + 2'd1;
			end else begin
				run_length_q    <= next_length;
				byte_in_plane_q <= byte_in_plane_q + 16'd1;
			end
		end
	end

	// output group register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			rd_q    <= 2'd0;
		end else if (in_accept) begin
			group_q <= group_d;
			rd_q    <= 2'd0;
		end else if (out_accept) begin
			if (last_of_item) begin
				group_q.count <= 3'd0;
				rd_q          <= 2'd0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	// an item is only taken when the previous group is gone or finishing
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (!out_valid || (!out_stall && last_of_item)))
		else $error("item accepted over a pending group");

	// end of line only marks the final byte of a group
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_end) |-> last_of_item)
		else $error("line end on a byte that is not last");

	// open run never grows beyond the pcx count limit
	assert property (@(posedge clk) disable iff (!arst_n)
		run_length_q <= RUN_LIMIT)
		else $error("run length above limit");

	// a group never holds more codes than one item can cause
	assert property (@(posedge clk) disable iff (!arst_n)
		group_q.count <= 3'(MAX_RESULTS))
		else $error("group count out of range");
`endif

endmodule

`default_nettype wire

>>> dv/tb_pcx_rle_line_encoder_top.sv
// testbench of the pcx run-length line encoder: directed and random scan lines
`timescale 1ns / 1ps

module tb_pcx_rle_line_encoder_top;
	import pcxrle_pkg::*;

	localparam int unsigned PLANE_BYTES_MAX = 65535;
	// generous bound on the whole run, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 500000;
	// the block answers in the cycle after taking an item; leave some margin
	localparam int unsigned SETTLE_CYCLES = 4;

	// one encoded byte as it should leave the block
	typedef struct packed {
		code_t code;
		logic  last_of_item;
		logic  line_end;
	} enc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [0:0]  wr_index = REG_BYTES_PER_PLANE;
	logic [15:0] wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  code_byte;
	logic        last_of_item;
	logic        line_end;

	// idling percentages of the sender and the receiver, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// encoder copy: configuration as written and the open run / plane position
	logic [15:0] cfg_plane_bytes = 16'd640;
	logic [2:0]  cfg_planes = 3'd1;
	logic [7:0]  run_val = '0;
	logic [5:0]  run_len = '0;
	logic [15:0] plane_pos = '0;
	logic [1:0]  plane_idx = '0;

	// codes of the item being encoded, and every code still owed by the block
	enc_byte_t item_codes[$];
	enc_byte_t pending_codes[$];

	pcx_rle_line_encoder_top #(
		.MAX_PLANE_BYTES(PLANE_BYTES_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_byte(code_byte),
		.last_of_item(last_of_item),
		.line_end(line_end)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- encoder copy

	task automatic emit_code(code_t c, logic le);
		item_codes.push_back('{code: c, last_of_item: 1'b0, line_end: le});
	endtask

	// close the open run: count byte when longer than one or when the value looks
	// like a count byte itself, then the value
	task automatic flush_run(logic le);
		if (run_len == 0)
			return;
		if (run_len > 1 || run_val[7:6] == 2'b11)
			emit_code(COUNT_MARK | {2'b00, run_len}, 1'b0);
		emit_code(run_val, le);
		run_len = '0;
	endtask

	// works out the codes caused by one accepted raw byte and queues them
	task automatic encode_byte(logic [7:0] b);
		int unsigned psize;
		int unsigned planes;
		psize = (cfg_plane_bytes == 0) ? 1 : cfg_plane_bytes;
		if (psize > PLANE_BYTES_MAX)
			psize = PLANE_BYTES_MAX;
		planes = (cfg_planes == 0) ? 1 : cfg_planes;
		if (planes > 4)
			planes = 4;
		item_codes.delete();

		// a different byte or a full run closes the open run first
		if (run_len != 0 && (b != run_val || run_len >= RUN_LIMIT))
			flush_run(1'b0);
		if (run_len == 0) begin
			run_val = b;
			run_len = 6'd1;
		end else begin
			run_len = run_len + 6'd1;
		end

		// the byte that ends a plane closes its run; on the last plane it ends the line
		if (32'(plane_pos) + 1 >= psize) begin
			plane_pos = '0;
			if (32'(plane_idx) + 1 >= planes) begin
				plane_idx = '0;
				flush_run(1'b1);
			end else begin
				plane_idx = plane_idx + 2'd1;
				flush_run(1'b0);
			end
		end else begin
			plane_pos = plane_pos + 16'd1;
		end

		if (item_codes.size() > 0)
			item_codes[item_codes.size() - 1].last_of_item = 1'b1;
		foreach (item_codes[i])
			pending_codes.push_back(item_codes[i]);
	endtask

	// ---------------------------------------------------------------- drivers

	// receiver stalls at random, as often as the phase asks
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// hands one raw byte over; in_valid stays high on return so back-to-back
	// items keep it high, and settle_block lowers it
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		encode_byte(b);
	endtask

	// stop sending and wait until every owed code has come out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes happen only with the block idle
	task automatic write_reg(reg_index_t idx, logic [15:0] v);
		settle_block();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_BYTES_PER_PLANE: cfg_plane_bytes = v;
			REG_PLANE_COUNT:     cfg_planes = v[2:0];
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- checker

	// every code taken from the block must match the oldest owed code
	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_codes.size() == 0) begin
				mismatches++;
				$display("%0t: expected no code, got code %h last %b line end %b",
					$time, code_byte, last_of_item, line_end);
			end else begin
				want = pending_codes.pop_front();
				if (code_byte !== want.code || last_of_item !== want.last_of_item ||
						line_end !== want.line_end) begin
					mismatches++;
					$display("%0t: expected %h last %b end %b, got %h last %b end %b",
						$time, want.code, want.last_of_item, want.line_end,
						code_byte, last_of_item, line_end);
				end
			end
		end
	end

	// hard stop if the block hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------- tests

	// reset settings (640-byte plane, one plane): repeats, count-looking values
	task automatic test_reset_defaults();
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hC0);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h7E);
	endtask

	// out-of-range and extreme sizes, written in the middle of a line
	task automatic test_plane_extremes();
		// zero plane size and zero plane count act as one: every byte is a whole line
		write_reg(REG_BYTES_PER_PLANE, 16'h0000);
		write_reg(REG_PLANE_COUNT, 16'h0000);
		send_byte(8'h7E);
		send_byte(8'hBF);
		send_byte(8'hC0);
		send_byte(8'h3F);
		// plane count 7 acts as 4, one-byte planes
		write_reg(REG_BYTES_PER_PLANE, 16'h0001);
		write_reg(REG_PLANE_COUNT, 16'hFFFF);
		send_byte(8'h01);
		send_byte(8'h01);
		send_byte(8'hC4);
		send_byte(8'hC4);
		send_byte(8'h80);
		// largest plane
		write_reg(REG_BYTES_PER_PLANE, 16'hFFFF);
		write_reg(REG_PLANE_COUNT, 16'h0004);
		send_byte(8'hAA);
		send_byte(8'hAA);
		send_byte(8'h55);
		// shrinking the plane below the current position ends it at once; then a
		// run closed by a high byte that ends the plane gives four codes
		write_reg(REG_BYTES_PER_PLANE, 16'h0003);
		write_reg(REG_PLANE_COUNT, 16'h0002);
		send_byte(8'h10);
		send_byte(8'h10);
		send_byte(8'h10);
		send_byte(8'hE0);
		send_byte(8'hE0);
		send_byte(8'hE0);
		send_byte(8'hE0);
	endtask

	// runs past 63 bytes split into full-length runs
	task automatic test_run_limit();
		write_reg(REG_BYTES_PER_PLANE, 16'hFFFF);
		write_reg(REG_PLANE_COUNT, 16'h0001);
		repeat (127) send_byte(8'hE7);
		send_byte(8'h11);
	endtask

	// mostly scan-line-like runs, sometimes long, sometimes high values, with noise
	task automatic send_runs(int unsigned n);
		int unsigned sent;
		int unsigned len;
		logic [7:0] val;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) == 0) begin
				send_byte(8'($urandom_range(255)));
				sent++;
			end else begin
				val = $urandom_range(1) ? 8'($urandom_range(8'hFF, 8'hC0)) :
					8'($urandom_range(255));
				len = ($urandom_range(7) == 0) ? $urandom_range(70, 20) :
					$urandom_range(4, 1);
				repeat (len) send_byte(val);
				sent += len;
			end
		end
	endtask

	// random geometry: mostly small planes so lines end often, now and then the extremes
	task automatic pick_line_geometry();
		logic [15:0] bpp;
		case ($urandom_range(5))
			0: bpp = 16'h0000;
			1: bpp = 16'hFFFF;
			2: bpp = 16'($urandom_range(65535));
			default: bpp = 16'($urandom_range(12, 1));
		endcase
		write_reg(REG_BYTES_PER_PLANE, bpp);
		write_reg(REG_PLANE_COUNT, 16'($urandom_range(65535)));
	endtask

	task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_level);
		send_idle_pct = idle_pct;
		stall_pct = stall_level;
		repeat (2) begin
			pick_line_geometry();
			send_runs(18);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_plane_extremes();
		test_run_limit();
		test_random_phase(0, 0);
		test_random_phase(60, 0);
		test_random_phase(0, 60);
		test_random_phase(28, 28);
		test_random_phase(0, 0);

		settle_block();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
